[rtl/nfa_pkg.sv]
// nfa_pkg: shared types and constants of the NFA acceptance engine.
// No dependencies; compiled first.
package nfa_pkg;

	// Fixed field widths of the item and result beats
	localparam int MASK_W = 16;
	localparam int SYM_W  = 8;
	localparam int FROM_W = 4;

	// Configuration port
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_START_MASK = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FINAL_MASK = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_EPS_SYMBOL = 2'd2;

	// Item operation codes
	typedef enum logic [1:0] {
		OP_LOAD_SYM = 2'd0,
		OP_LOAD_EPS = 2'd1,
		OP_START    = 2'd2,
		OP_FEED     = 2'd3
	} op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_STEP,
		ST_CLOSE,
		ST_DONE
	} seq_state_t;

	// Per-cycle commands broadcast to every state cell
	typedef struct packed {
		logic mem_we;  // write symbol row memory (selected cells)
		logic eps_we;  // write epsilon row (selected cells)
		logic rd_en;   // read symbol row memory
		logic act_we;  // load active bit
	} cell_ctrl_t;

endpackage

[rtl/nfa_if.sv]
// nfa_if: valid/ready stream interfaces for item and result beats.
// Depends on nfa_pkg.
interface nfa_in_if;
	import nfa_pkg::*;

	logic                valid;
	logic                ready;
	op_t                 op;
	logic [FROM_W-1:0]   src_state;
	logic [SYM_W-1:0]    symbol;
	logic [MASK_W-1:0]   next_mask;
	logic                word_end;

	modport source (output valid, op, src_state, symbol, next_mask, word_end, input ready);
	modport sink   (input valid, op, src_state, symbol, next_mask, word_end, output ready);
endinterface

interface nfa_out_if;
	import nfa_pkg::*;

	logic                valid;
	logic                ready;
	logic [MASK_W-1:0]   active_states;
	logic                accepted;
	logic                verdict_final;

	modport source (output valid, active_states, accepted, verdict_final, input ready);
	modport sink   (input valid, active_states, accepted, verdict_final, output ready);
endinterface

[rtl/nfa_cell.sv]
// nfa_cell: one automaton state: its symbol row memory, epsilon row and
// active bit, plus its link in the OR chains. Depends on nfa_pkg.
module nfa_cell #(
	parameter int SW = 16,
	parameter int AW = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  nfa_pkg::cell_ctrl_t ctrl,
	input  logic                sel,
	input  logic [AW-1:0]       addr,
	input  logic [SW-1:0]       wdata,
	input  logic                act_d,
	output logic                act,
	input  logic [SW-1:0]       sym_acc_in,
	output logic [SW-1:0]       sym_acc_out,
	input  logic [SW-1:0]       eps_acc_in,
	output logic [SW-1:0]       eps_acc_out
);
	import nfa_pkg::*;

	localparam int DEPTH = 1 << AW;

	logic [SW-1:0] sym_mem [DEPTH];
	logic [SW-1:0] rd_row_q;
	logic [SW-1:0] eps_row_q;
	logic          act_q;

	// Symbol row memory: one write port, registered read
	always_ff @(posedge clk) begin
		if (ctrl.mem_we && sel) begin
			sym_mem[addr] <= wdata;
		end
		if (ctrl.rd_en) begin
			rd_row_q <= sym_mem[addr];
		end
	end

	// Epsilon row and active bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_row_q <= '0;
			act_q     <= 1'b0;
		end else begin
			if (ctrl.eps_we && sel) begin
				eps_row_q <= wdata;
			end
			if (ctrl.act_we) begin
				act_q <= act_d;
			end
		end
	end

	assign act = act_q;

	// Pass the unions on to the next cell, adding this state's rows if active
	assign sym_acc_out = sym_acc_in | (act_q ? rd_row_q : '0);
	assign eps_acc_out = eps_acc_in | (act_q ? eps_row_q : '0);

endmodule

[rtl/nfa_acceptance_engine.sv]
// nfa_acceptance_engine: NFA with epsilon moves run over a symbol stream.
// From accept to result valid: loads and skipped epsilon feeds go straight to the result
// register; start runs epsilon closure rounds; feed takes a symbol step, then closure rounds.
// One item at a time: the next item is taken the cycle after its result is registered.
// Reset: async, active low; a clearing pass zeroes all 2^SYMBOL_BITS rows of the
// symbol row memories, with no item taken meanwhile. Depends on nfa_pkg, nfa_if, nfa_cell.
module nfa_acceptance_engine #(
	parameter int NUM_STATES  = 16,
	parameter int SYMBOL_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nfa_pkg::APB_AW-1:0]  paddr,
	input  logic [nfa_pkg::APB_DW-1:0]  pwdata,
	output logic [nfa_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	nfa_in_if.sink                      item_in,
	nfa_out_if.source                   result_out
);
	import nfa_pkg::*;

	localparam int SW = (NUM_STATES < MASK_W) ? NUM_STATES : MASK_W;
	localparam int AW = SYMBOL_BITS;

	// Configuration registers
	logic [MASK_W-1:0] start_mask_q;
	logic [MASK_W-1:0] final_mask_q;
	logic [SYM_W-1:0]  eps_sym_q;
	logic              cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;

	// Sequencer
	seq_state_t    st_q, st_d;
	logic [AW-1:0] clr_cnt_q;
	logic          verdict_q;
	logic          in_fire;
	logic          feed_eps;
	logic          out_load;

	// Cell control
	cell_ctrl_t    ctrl;
	logic [SW-1:0] sel;
	logic [SW-1:0] from_sel;
	logic [AW-1:0] sym_idx;
	logic [AW-1:0] mem_addr;
	logic [SW-1:0] mem_wdata;
	logic [SW-1:0] act_d;
	logic [SW-1:0] act;
	logic [SW-1:0] sym_chain [SW+1];
	logic [SW-1:0] eps_chain [SW+1];
	logic [SW-1:0] grown;
	logic          stable;

	// Result register
	logic              out_valid_q;
	logic [MASK_W-1:0] out_active_q;
	logic              out_accepted_q;
	logic              out_verdict_q;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[APB_AW-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_mask_q <= '0;
			final_mask_q <= '0;
			eps_sym_q    <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_START_MASK: start_mask_q <= pwdata[MASK_W-1:0];
				REG_FINAL_MASK: final_mask_q <= pwdata[MASK_W-1:0];
				REG_EPS_SYMBOL: eps_sym_q    <= pwdata[SYM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_START_MASK: prdata = APB_DW'(start_mask_q);
			REG_FINAL_MASK: prdata = APB_DW'(final_mask_q);
			REG_EPS_SYMBOL: prdata = APB_DW'(eps_sym_q);
			default:        prdata = '0;
		endcase
	end

	// ---------------- item decode ----------------
	assign item_in.ready = (st_q == ST_IDLE);
	assign in_fire       = item_in.valid && item_in.ready;
	assign feed_eps      = (item_in.symbol == eps_sym_q);
	assign sym_idx       = AW'(item_in.symbol);

	// Row select; states at or above the cell count match no cell
	always_comb begin
		for (int i = 0; i < SW; i++) begin
			from_sel[i] = (item_in.src_state == FROM_W'(i));
		end
	end

	// Closure round: add epsilon targets of all active states
	assign grown  = act | eps_chain[SW];
	assign stable = (grown == act);

	// ---------------- sequencer next state ----------------
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_CLEAR: begin
				if (clr_cnt_q == '1) st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_fire) begin
					unique case (item_in.op)
						OP_LOAD_SYM, OP_LOAD_EPS: st_d = ST_DONE;
						OP_START:                 st_d = ST_CLOSE;
						OP_FEED:                  st_d = feed_eps ? ST_DONE : ST_STEP;
						default:                  st_d = ST_IDLE;
					endcase
				end
			end
			ST_STEP: st_d = ST_CLOSE;
			ST_CLOSE: begin
				if (stable) st_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || result_out.ready) st_d = ST_IDLE;
			end
			default: st_d = ST_CLEAR;
		endcase
	end

	// ---------------- sequencer outputs ----------------
	always_comb begin
		ctrl      = '0;
		sel       = '0;
		act_d     = act;
		mem_addr  = sym_idx;
		mem_wdata = SW'(item_in.next_mask);
		out_load  = 1'b0;
		unique case (st_q)
			ST_CLEAR: begin
				ctrl.mem_we = 1'b1;
				sel         = '1;
				mem_addr    = clr_cnt_q;
				mem_wdata   = '0;
			end
			ST_IDLE: begin
				if (in_fire) begin
					unique case (item_in.op)
						OP_LOAD_SYM: begin
							ctrl.mem_we = 1'b1;
							sel         = from_sel;
						end
						OP_LOAD_EPS: begin
							ctrl.eps_we = 1'b1;
							sel         = from_sel;
						end
						OP_START: begin
							ctrl.act_we = 1'b1;
							act_d       = SW'(start_mask_q);
						end
						OP_FEED: begin
							ctrl.rd_en = !feed_eps;
						end
						default: ;
					endcase
				end
			end
			ST_STEP: begin
				ctrl.act_we = 1'b1;
				act_d       = sym_chain[SW];
			end
			ST_CLOSE: begin
				ctrl.act_we = !stable;
				act_d       = grown;
			end
			ST_DONE: begin
				out_load = !out_valid_q || result_out.ready;
			end
			default: ;
		endcase
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLEAR;
			clr_cnt_q <= '0;
			verdict_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (in_fire) begin
				verdict_q <= ((item_in.op == OP_START) || (item_in.op == OP_FEED))
					&& item_in.word_end;
			end
		end
	end

	// ---------------- cell chain ----------------
	assign sym_chain[0] = '0;
	assign eps_chain[0] = '0;

	for (genvar g = 0; g < SW; g++) begin : g_cell
		nfa_cell #(
			.SW (SW),
			.AW (AW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.sel         (sel[g]),
			.addr        (mem_addr),
			.wdata       (mem_wdata),
			.act_d       (act_d[g]),
			.act         (act[g]),
			.sym_acc_in  (sym_chain[g]),
			.sym_acc_out (sym_chain[g+1]),
			.eps_acc_in  (eps_chain[g]),
			.eps_acc_out (eps_chain[g+1])
		);
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_active_q   <= MASK_W'(act);
			out_accepted_q <= |(act & SW'(final_mask_q));
			out_verdict_q  <= verdict_q;
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.active_states = out_active_q;
	assign result_out.accepted      = out_accepted_q;
	assign result_out.verdict_final = out_verdict_q;

endmodule
